FILE: rtl/red_pkg.sv
// shared types, codes and constants of the riff endianness detector
package red_pkg;

   localparam int NAME_SLOTS   = 6;
   localparam int MATCH_W      = $clog2(NAME_SLOTS + 1);
   localparam int WINDOW_BYTES = 8;
   localparam int FLUSH_STEPS  = 4;
   localparam int STEP_W       = $clog2(FLUSH_STEPS + 1);
   localparam int QUEUE_DEPTH  = 4;
   localparam int QUEUE_AW     = $clog2(QUEUE_DEPTH);

   localparam logic [31:0] MARK_RIFF = 32'h52494646;
   localparam logic [31:0] MARK_RIFX = 32'h52494658;

   // register indexes
   localparam logic [2:0] CSR_FILE_SIZE  = 3'd0;
   localparam logic [2:0] CSR_NAME_COUNT = 3'd1;
   localparam logic [2:0] CSR_NAME_0     = 3'd2;

   // byte order codes
   localparam logic [1:0] ORDER_LITTLE  = 2'd0;
   localparam logic [1:0] ORDER_BIG     = 2'd1;
   localparam logic [1:0] ORDER_UNKNOWN = 2'd2;

   // decision source codes
   localparam logic [1:0] BY_HEADER = 2'd0;
   localparam logic [1:0] BY_MARKER = 2'd1;
   localparam logic [1:0] BY_VOTE   = 2'd2;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      logic [1:0]  byte_order;
      logic [1:0]  decided_by;
      logic [31:0] little_votes;
      logic [31:0] big_votes;
   } rsp_type;

   typedef struct packed {
      logic [31:0]                  file_size;
      logic [2:0]                   name_count;
      logic [NAME_SLOTS-1:0][31:0]  names;
   } cfg_type;

   typedef struct packed {
      logic [1:0] byte_order;
      logic [1:0] decided_by;
   } dec_type;

   typedef struct packed {
      logic        final_job;
      logic        vote;
      logic [63:0] window;
      dec_type     dec;
   } job_type;

   typedef enum logic {
      FS_RUN,
      FS_FLUSH
   } front_state_type;

   function automatic logic [31:0] byte_swap(input logic [31:0] w);
      byte_swap = {w[7:0], w[15:8], w[23:16], w[31:24]};
   endfunction

endpackage

FILE: rtl/red_queue.sv
// job queue between the byte front end and the vote back end
module red_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  red_pkg::job_type  push_job,
   input  logic              pop,
   output red_pkg::job_type  head_job,
   output logic              full,
   output logic              empty
);

   red_pkg::job_type                  mem_ff [red_pkg::QUEUE_DEPTH];
   logic [red_pkg::QUEUE_AW-1:0]      wr_ptr_ff;
   logic [red_pkg::QUEUE_AW-1:0]      rd_ptr_ff;
   logic [red_pkg::QUEUE_AW:0]        count_ff;
   logic                              do_push;
   logic                              do_pop;

   assign full     = (count_ff == (red_pkg::QUEUE_AW + 1)'(red_pkg::QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign head_job = mem_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

FILE: rtl/red_front.sv
// byte front end: window, header and marker tracking, vote job issue and flush
module red_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  red_pkg::req_type  req_item,
   output logic              push,
   output red_pkg::job_type  push_job,
   input  logic              queue_full
);

   red_pkg::front_state_type     state_ff;
   red_pkg::front_state_type     state_in;
   logic [63:0]                  window_ff;
   logic [31:0]                  position_ff;
   logic [31:0]                  header_ff;
   logic                         riff_ff;
   logic                         rifx_ff;
   logic [red_pkg::STEP_W-1:0]   step_ff;

   logic [63:0]                  window_in;
   logic [31:0]                  low_word;
   logic                         accept;
   logic                         flush_go;
   logic                         flush_done;
   logic [63:0]                  flush_window;
   logic                         flush_vote;
   red_pkg::dec_type             dec;

   assign window_in  = {window_ff[55:0], req_item.data_byte};
   assign low_word   = window_in[31:0];
   assign accept     = req_valid && req_ready;
   assign flush_go   = (state_ff == red_pkg::FS_FLUSH) && !queue_full;
   assign flush_done = flush_go && (step_ff == red_pkg::STEP_W'(red_pkg::FLUSH_STEPS));
   assign flush_vote = ({1'b0, position_ff} + 33'(step_ff)) >= 33'(red_pkg::WINDOW_BYTES);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         red_pkg::FS_RUN: begin
            if (accept && req_item.last_byte) begin
               state_in = red_pkg::FS_FLUSH;
            end
         end
         red_pkg::FS_FLUSH: begin
            if (flush_done) begin
               state_in = red_pkg::FS_RUN;
            end
         end
         default: state_in = red_pkg::FS_RUN;
      endcase
   end

   // window shifted past the end of the file, zero bytes move in
   always_comb begin
      case (step_ff)
         red_pkg::STEP_W'(1): flush_window = {window_ff[55:0], 8'h00};
         red_pkg::STEP_W'(2): flush_window = {window_ff[47:0], 16'h0000};
         red_pkg::STEP_W'(3): flush_window = {window_ff[39:0], 24'h000000};
         red_pkg::STEP_W'(4): flush_window = {window_ff[31:0], 32'h00000000};
         default:             flush_window = window_ff;
      endcase
   end

   // header and marker decision, taken from the settled stream state
   always_comb begin
      if (header_ff == red_pkg::MARK_RIFF) begin
         dec = '{byte_order: red_pkg::ORDER_LITTLE, decided_by: red_pkg::BY_HEADER};
      end else if (header_ff == red_pkg::MARK_RIFX) begin
         dec = '{byte_order: red_pkg::ORDER_BIG, decided_by: red_pkg::BY_HEADER};
      end else if (riff_ff && !rifx_ff) begin
         dec = '{byte_order: red_pkg::ORDER_LITTLE, decided_by: red_pkg::BY_MARKER};
      end else if (rifx_ff && !riff_ff) begin
         dec = '{byte_order: red_pkg::ORDER_BIG, decided_by: red_pkg::BY_MARKER};
      end else begin
         dec = '{byte_order: red_pkg::ORDER_UNKNOWN, decided_by: red_pkg::BY_VOTE};
      end
   end

   // outputs
   always_comb begin
      req_ready = 1'b0;
      push      = 1'b0;
      push_job  = '{final_job: 1'b0,
                    vote: (position_ff >= 32'(red_pkg::WINDOW_BYTES - 1)),
                    window: window_in,
                    dec: dec};
      case (state_ff)
         red_pkg::FS_RUN: begin
            req_ready = !queue_full;
            push      = accept;
         end
         red_pkg::FS_FLUSH: begin
            push     = flush_go;
            push_job = '{final_job: (step_ff == red_pkg::STEP_W'(red_pkg::FLUSH_STEPS)),
                         vote: flush_vote,
                         window: flush_window,
                         dec: dec};
         end
         default: begin
            req_ready = 1'b0;
            push      = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= red_pkg::FS_RUN;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || flush_done) begin
         window_ff   <= '0;
         position_ff <= '0;
         header_ff   <= '0;
         riff_ff     <= 1'b0;
         rifx_ff     <= 1'b0;
         step_ff     <= '0;
      end else if (accept) begin
         window_ff <= window_in;
         if (position_ff != '1) begin
            position_ff <= position_ff + 32'd1;
         end
         if (position_ff == 32'd3) begin
            header_ff <= low_word;
         end
         if (position_ff >= 32'd3) begin
            if (low_word == red_pkg::MARK_RIFF) begin
               riff_ff <= 1'b1;
            end
            if (low_word == red_pkg::MARK_RIFX) begin
               rifx_ff <= 1'b1;
            end
         end
         step_ff <= red_pkg::STEP_W'(1);
      end else if (flush_go) begin
         step_ff <= step_ff + 1'b1;
      end
   end

endmodule

FILE: rtl/red_back.sv
// vote back end: name match, distance compare, saturating counters, result register
module red_back (
   input  logic              clock,
   input  logic              reset,
   input  red_pkg::cfg_type  cfg,
   input  red_pkg::job_type  head_job,
   input  logic              empty,
   output logic              pop,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output red_pkg::rsp_type  rsp_item
);

   logic                          adv;
   logic [2:0]                    active_count;
   logic [red_pkg::MATCH_W-1:0]   match_n;
   logic [31:0]                   half;

   // stage 1: name match and the two readings
   logic                          s1_valid_ff;
   logic                          s1_final_ff;
   red_pkg::dec_type              s1_dec_ff;
   logic [red_pkg::MATCH_W-1:0]   s1_matches_ff;
   logic [31:0]                   s1_le_ff;
   logic [31:0]                   s1_be_ff;
   // stage 2: distances to half the size
   logic                          s2_valid_ff;
   logic                          s2_final_ff;
   red_pkg::dec_type              s2_dec_ff;
   logic [red_pkg::MATCH_W-1:0]   s2_matches_ff;
   logic [31:0]                   s2_dle_ff;
   logic [31:0]                   s2_dbe_ff;
   // stage 3: which side gains
   logic                          s3_valid_ff;
   logic                          s3_final_ff;
   red_pkg::dec_type              s3_dec_ff;
   logic [red_pkg::MATCH_W-1:0]   s3_matches_ff;
   logic                          s3_lgain_ff;
   logic                          s3_bgain_ff;

   logic [31:0]                   little_ff;
   logic [31:0]                   big_ff;
   logic [31:0]                   little_in;
   logic [31:0]                   big_in;
   logic [32:0]                   little_sum;
   logic [32:0]                   big_sum;
   logic                          emit_ff;
   red_pkg::dec_type              dec_ff;
   logic                          rsp_valid_ff;
   red_pkg::rsp_type              rsp_item_ff;
   red_pkg::rsp_type              result;

   assign adv  = !emit_ff;
   assign pop  = adv && !empty;
   assign half = cfg.file_size >> 1;

   always_comb begin
      active_count = (cfg.name_count > 3'(red_pkg::NAME_SLOTS)) ?
                     3'(red_pkg::NAME_SLOTS) : cfg.name_count;
      match_n = '0;
      for (int i = 0; i < red_pkg::NAME_SLOTS; i++) begin
         if ((3'(i) < active_count) && (cfg.names[i] == head_job.window[63:32])) begin
            match_n = match_n + red_pkg::MATCH_W'(1);
         end
      end
   end

   assign little_sum = {1'b0, little_ff} + 33'(s3_lgain_ff ? s3_matches_ff : '0);
   assign big_sum    = {1'b0, big_ff} + 33'(s3_bgain_ff ? s3_matches_ff : '0);
   assign little_in  = little_sum[32] ? '1 : little_sum[31:0];
   assign big_in     = big_sum[32] ? '1 : big_sum[31:0];

   always_comb begin
      result.decided_by   = dec_ff.decided_by;
      result.little_votes = little_ff;
      result.big_votes    = big_ff;
      if (dec_ff.decided_by != red_pkg::BY_VOTE) begin
         result.byte_order = dec_ff.byte_order;
      end else if (little_ff > big_ff) begin
         result.byte_order = red_pkg::ORDER_LITTLE;
      end else if (big_ff > little_ff) begin
         result.byte_order = red_pkg::ORDER_BIG;
      end else begin
         result.byte_order = red_pkg::ORDER_UNKNOWN;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         little_ff    <= '0;
         big_ff       <= '0;
         emit_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (adv) begin
            if (rsp_valid_ff && rsp_ready) begin
               rsp_valid_ff <= 1'b0;
            end
            s1_valid_ff <= pop;
            s2_valid_ff <= s1_valid_ff;
            s3_valid_ff <= s2_valid_ff;
            if (s3_valid_ff) begin
               little_ff <= little_in;
               big_ff    <= big_in;
               if (s3_final_ff) begin
                  emit_ff <= 1'b1;
               end
            end
         end else if (!rsp_valid_ff || rsp_ready) begin
            rsp_valid_ff <= 1'b1;
            little_ff    <= '0;
            big_ff       <= '0;
            emit_ff      <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_final_ff   <= head_job.final_job;
         s1_dec_ff     <= head_job.dec;
         s1_matches_ff <= head_job.vote ? match_n : '0;
         s1_be_ff      <= head_job.window[31:0];
         s1_le_ff      <= red_pkg::byte_swap(head_job.window[31:0]);
         s2_final_ff   <= s1_final_ff;
         s2_dec_ff     <= s1_dec_ff;
         s2_matches_ff <= s1_matches_ff;
         s2_dle_ff     <= (half > s1_le_ff) ? (half - s1_le_ff) : (s1_le_ff - half);
         s2_dbe_ff     <= (half > s1_be_ff) ? (half - s1_be_ff) : (s1_be_ff - half);
         s3_final_ff   <= s2_final_ff;
         s3_dec_ff     <= s2_dec_ff;
         s3_matches_ff <= s2_matches_ff;
         s3_lgain_ff   <= s2_dbe_ff > s2_dle_ff;
         s3_bgain_ff   <= s2_dle_ff > s2_dbe_ff;
         if (s3_valid_ff && s3_final_ff) begin
            dec_ff <= s3_dec_ff;
         end
      end else if (!rsp_valid_ff || rsp_ready) begin
         rsp_item_ff <= result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

endmodule

FILE: rtl/riff_endianness_detector.sv
// top level of the riff endianness detector: config registers, front, queue, back
// throughput: one byte item per cycle while the job queue is not full; each last byte
// is followed by four flush jobs, during which no byte item is taken
// result path: flush jobs, queue, three vote stages, counter update, result register
// reset: synchronous active-high reset clears config registers, stream state,
// vote counters, queue pointers, pipeline valid flags and result valid flag
module riff_endianness_detector (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  red_pkg::req_type  req_item,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output red_pkg::rsp_type  rsp_item,
   input  logic              csr_write_en,
   input  logic [2:0]        csr_index,
   input  logic [31:0]       csr_wdata
);

   red_pkg::cfg_type   cfg_ff;
   logic               push;
   red_pkg::job_type   push_job;
   logic               pop;
   red_pkg::job_type   head_job;
   logic               queue_full;
   logic               queue_empty;

   // config registers; the user must write them only while idle, the block does not enforce it
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_write_en) begin
         if (csr_index == red_pkg::CSR_FILE_SIZE) begin
            cfg_ff.file_size <= csr_wdata;
         end
         if (csr_index == red_pkg::CSR_NAME_COUNT) begin
            cfg_ff.name_count <= csr_wdata[2:0];
         end
         for (int i = 0; i < red_pkg::NAME_SLOTS; i++) begin
            if (csr_index == (red_pkg::CSR_NAME_0 + 3'(i))) begin
               cfg_ff.names[i] <= csr_wdata;
            end
         end
      end
   end

   // front end: takes bytes, tracks header and markers, issues one vote job per
   // byte and four flush jobs after the last byte
   red_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_item   (req_item),
      .push       (push),
      .push_job   (push_job),
      .queue_full (queue_full)
   );

   // short job queue so either side can stall on its own
   red_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .head_job (head_job),
      .full     (queue_full),
      .empty    (queue_empty)
   );

   // back end: matches names, compares distances to half size, counts votes,
   // and forms the result when the final job of a file arrives
   red_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .head_job  (head_job),
      .empty     (queue_empty),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_item  (rsp_item)
   );

   // no byte is taken while the job queue is full
   a_full_blocks: assert property (@(posedge clock) disable iff (reset)
      queue_full |-> !req_ready)
      else $error("byte item taken with job queue full");

   // a last byte starts the flush, which holds off the next byte
   a_flush_stall: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_item.last_byte) |=> !req_ready)
      else $error("byte item taken during end-of-file flush");

   // header and marker decisions always name a byte order
   a_known_order: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_item.decided_by != red_pkg::BY_VOTE))
         |-> (rsp_item.byte_order != red_pkg::ORDER_UNKNOWN))
      else $error("header or marker decision without byte order");

   // a little endian vote result carries more little votes
   a_vote_little: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_item.decided_by == red_pkg::BY_VOTE)
         && (rsp_item.byte_order == red_pkg::ORDER_LITTLE))
         |-> (rsp_item.little_votes > rsp_item.big_votes))
      else $error("vote result disagrees with vote counts");

endmodule

FILE: tb/sv/tb_riff_endianness_detector.sv
// self-checking testbench of the riff endianness detector: directed table, then random files
module tb_riff_endianness_detector;
   timeunit 1ns;
   timeprecision 1ps;

   // pause after the last result before touching registers (result latency plus margin)
   localparam int DRAIN_CYCLES  = 12;
   // cycles without any handshake or register write before the run is declared hung
   localparam int STALL_LIMIT   = 1000;
   // random part: stop after this many bytes
   localparam int RANDOM_BYTES  = 360;

   // a directed file: optional register setup, up to nine bytes, optional typed verdict
   typedef struct packed {
      bit                 set_regs;
      logic [31:0]        size;
      logic [2:0]         count;
      logic [31:0]        name;
      int                 len;
      logic [71:0]        bytes;
      bit                 typed;
      red_pkg::rsp_type   verdict;
   } probe_row_type;

   logic     clock = 1'b0;
   logic     reset = 1'b1;
   logic     req_valid = 1'b0;
   logic     req_ready;
   red_pkg::req_type  req_item = '0;
   logic     rsp_valid;
   logic     rsp_ready = 1'b1;
   red_pkg::rsp_type  rsp_item;
   logic        csr_write_en = 1'b0;
   logic [2:0]  csr_index = '0;
   logic [31:0] csr_wdata = '0;

   riff_endianness_detector i_dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_item     (req_item),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_item     (rsp_item),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // ------------------------------------------------------------------
   // detector prediction: register copies and stream state
   // ------------------------------------------------------------------
   logic [31:0] size_reg  = '0;
   logic [2:0]  count_reg = '0;
   logic [31:0] name_regs [red_pkg::NAME_SLOTS];

   logic [63:0] window_q    = '0;  // last eight bytes, newest in the low byte
   logic [31:0] seen_count  = '0;  // bytes of the current file, saturating
   logic [31:0] head_word   = '0;  // first four bytes of the file
   bit          riff_hit    = 1'b0;
   bit          rifx_hit    = 1'b0;
   logic [31:0] little_tally = '0;
   logic [31:0] big_tally    = '0;

   red_pkg::rsp_type pending_verdicts [$];  // verdicts still to come out of the block
   red_pkg::rsp_type typed_verdicts [$];    // hand-written verdicts of directed files
   logic [7:0] file_bytes [$];     // file under construction

   int  failures      = 0;
   int  bytes_sent    = 0;
   bit  req_rush      = 1'b0;      // sender runs without gaps
   bit  rsp_rush      = 1'b0;      // receiver runs without stalls
   int  ready_hold    = 0;
   int  idle_cycles   = 0;

   initial begin
      for (int i = 0; i < red_pkg::NAME_SLOTS; i++) name_regs[i] = '0;
   end

   // one name match: the four bytes after the name vote for the reading closer to half size
   task automatic cast_votes(input logic [63:0] w);
      logic [31:0] tag, as_big, as_little, half, dist_little, dist_big;
      int active;
      tag       = w[63:32];
      as_big    = w[31:0];
      as_little = {as_big[7:0], as_big[15:8], as_big[23:16], as_big[31:24]};
      half      = size_reg >> 1;
      dist_little = (half > as_little) ? half - as_little : as_little - half;
      dist_big    = (half > as_big) ? half - as_big : as_big - half;
      // a count beyond the slots just means all slots
      active = (count_reg > red_pkg::NAME_SLOTS) ? red_pkg::NAME_SLOTS : int'(count_reg);
      for (int i = 0; i < active; i++) begin
         if (name_regs[i] == tag) begin
            // equal distances cast no vote; counters stick at all ones
            if (dist_big > dist_little && little_tally != '1) little_tally = little_tally + 1;
            if (dist_little > dist_big && big_tally != '1) big_tally = big_tally + 1;
         end
      end
   endtask

   // advance the detector by one accepted byte item; a last byte queues a verdict
   task automatic advance_detector(input red_pkg::req_type r);
      logic [32:0] cnt;
      logic [31:0] low;
      red_pkg::rsp_type v;
      cnt      = {1'b0, seen_count} + 33'd1;
      window_q = {window_q[55:0], r.data_byte};
      low      = window_q[31:0];
      if (cnt == 33'd4) head_word = low;
      if (cnt >= 33'd4) begin
         if (low == red_pkg::MARK_RIFF) riff_hit = 1'b1;
         if (low == red_pkg::MARK_RIFX) rifx_hit = 1'b1;
      end
      if (cnt >= 33'd8) cast_votes(window_q);
      seen_count = cnt[32] ? '1 : cnt[31:0];
      if (r.last_byte) begin
         // names near the end: length bytes past the end read as zero
         for (int k = 1; k <= 4; k++) begin
            if (cnt + 33'(k) >= 33'd8) cast_votes(window_q << (8 * k));
         end
         v.little_votes = little_tally;
         v.big_votes    = big_tally;
         if (head_word == red_pkg::MARK_RIFF) begin
            v.byte_order = red_pkg::ORDER_LITTLE;
            v.decided_by = red_pkg::BY_HEADER;
         end else if (head_word == red_pkg::MARK_RIFX) begin
            v.byte_order = red_pkg::ORDER_BIG;
            v.decided_by = red_pkg::BY_HEADER;
         end else if (riff_hit && !rifx_hit) begin
            v.byte_order = red_pkg::ORDER_LITTLE;
            v.decided_by = red_pkg::BY_MARKER;
         end else if (rifx_hit && !riff_hit) begin
            v.byte_order = red_pkg::ORDER_BIG;
            v.decided_by = red_pkg::BY_MARKER;
         end else begin
            v.decided_by = red_pkg::BY_VOTE;
            if (little_tally > big_tally) v.byte_order = red_pkg::ORDER_LITTLE;
            else if (big_tally > little_tally) v.byte_order = red_pkg::ORDER_BIG;
            else v.byte_order = red_pkg::ORDER_UNKNOWN;
         end
         // a directed file with a hand-written verdict replaces the computed one
         if (typed_verdicts.size() != 0) v = typed_verdicts.pop_front();
         pending_verdicts.push_back(v);
         // stream state starts over, registers stay
         window_q     = '0;
         seen_count   = '0;
         head_word    = '0;
         riff_hit     = 1'b0;
         rifx_hit     = 1'b0;
         little_tally = '0;
         big_tally    = '0;
      end
   endtask

   task automatic check_field(input string what, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         $display("%0t ns: %s mismatch, expected %h, actual %h", $time, what, want, got);
         failures++;
      end
   endtask

   // ------------------------------------------------------------------
   // monitor: both handshakes are sampled at the rising edge
   // ------------------------------------------------------------------
   always @(posedge clock) begin : watch_ports
      red_pkg::rsp_type want;
      if (!reset && req_valid && req_ready) advance_detector(req_item);
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_verdicts.size() == 0) begin
            $display("%0t ns: verdict with none expected, expected nothing, actual %h",
                     $time, rsp_item);
            failures++;
         end else begin
            want = pending_verdicts.pop_front();
            check_field("byte_order", 32'(want.byte_order), 32'(rsp_item.byte_order));
            check_field("decided_by", 32'(want.decided_by), 32'(rsp_item.decided_by));
            check_field("little_votes", want.little_votes, rsp_item.little_votes);
            check_field("big_votes", want.big_votes, rsp_item.big_votes);
         end
      end
   end

   // receiver: after each verdict, hold ready low for a random hold (none in rush mode), counted down while valid
   always @(posedge clock) begin
      if (rsp_valid && rsp_ready) ready_hold = rsp_rush ? 0 : $urandom_range(0, 7);
      else if (rsp_valid && ready_hold != 0) ready_hold = ready_hold - 1;
      rsp_ready <= (ready_hold == 0);
   end

   // watchdog: too long without any handshake or register write
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_write_en) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("%0t ns: no progress for %0d cycles", $time, STALL_LIMIT);
         $display("TEST FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // ------------------------------------------------------------------
   // drivers; every task starts and ends just after a rising edge
   // ------------------------------------------------------------------

   // let every verdict come out and the flush finish
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_verdicts.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // one register write; the caller drops the write enable after the last one
   task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= value;
      @(posedge clock);
      if (idx == red_pkg::CSR_FILE_SIZE) size_reg = value;
      else if (idx == red_pkg::CSR_NAME_COUNT) count_reg = value[2:0];
      else name_regs[idx - red_pkg::CSR_NAME_0] = value;
   endtask

   task automatic send_byte(input logic [7:0] data, input logic last);
      int gap;
      gap = req_rush ? 0 : $urandom_range(0, 7);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid           <= 1'b1;
      req_item.data_byte  <= data;
      req_item.last_byte  <= last;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      bytes_sent++;
   endtask

   task automatic send_file();
      for (int i = 0; i < file_bytes.size(); i++) begin
         send_byte(file_bytes[i], i == file_bytes.size() - 1);
      end
   endtask

   task automatic add_probe(input bit set_regs, input logic [31:0] size,
                            input logic [2:0] count, input logic [31:0] name,
                            input int len, input logic [71:0] bytes, input bit typed,
                            input logic [1:0] order, input logic [1:0] by,
                            inout probe_row_type rows [$]);
      probe_row_type row;
      row.set_regs = set_regs;
      row.size     = size;
      row.count    = count;
      row.name     = name;
      row.len      = len;
      row.bytes    = bytes;
      row.typed    = typed;
      row.verdict  = {order, by, 64'd0};
      rows.push_back(row);
   endtask

   // store a word big-endian at byte p, cut off at the end of the file
   task automatic place_word(input int p, input logic [31:0] w);
      for (int j = 0; j < 4; j++) begin
         if (p + j < file_bytes.size()) file_bytes[p + j] = w[31 - 8 * j -: 8];
      end
   endtask

   function automatic logic [31:0] pick_name();
      case ($urandom_range(0, 6))
         0: return 32'h64617461;   // data
         1: return 32'h666d7420;   // fmt
         2: return 32'h4c495354;   // LIST
         3: return red_pkg::MARK_RIFF;
         4: return 32'h00000000;
         5: return 32'hffffffff;
         default: return $urandom;
      endcase
   endfunction

   function automatic int pick_length();
      if ($urandom_range(0, 9) == 0) return $urandom_range(25, 80);
      return $urandom_range(1, 24);
   endfunction

   // length word after a name: near half size big- or little-endian, a tie, or noise
   function automatic logic [31:0] pick_length_word();
      logic [31:0] v;
      logic [7:0]  a, b;
      v = (size_reg >> 1) + 32'($urandom_range(0, 8)) - 32'd4;
      a = 8'($urandom);
      b = 8'($urandom);
      case ($urandom_range(0, 4))
         0, 1: return v;
         2: return {v[7:0], v[15:8], v[23:16], v[31:24]};
         3: return {a, b, b, a};    // both readings equal: no vote
         default: return $urandom;
      endcase
   endfunction

   // random file of len bytes with planted names, markers and header
   task automatic build_file(input int len);
      int hits, p;
      file_bytes = {};
      for (int i = 0; i < len; i++) file_bytes.push_back(8'($urandom));
      hits = $urandom_range(0, 3);
      for (int h = 0; h < hits; h++) begin
         p = $urandom_range(0, len - 1);
         place_word(p, name_regs[$urandom_range(0, red_pkg::NAME_SLOTS - 1)]);
         place_word(p + 4, pick_length_word());
      end
      case ($urandom_range(0, 3))
         1: place_word($urandom_range(0, len - 1), red_pkg::MARK_RIFF);
         2: place_word($urandom_range(0, len - 1), red_pkg::MARK_RIFX);
         3: begin
            place_word($urandom_range(0, len - 1), red_pkg::MARK_RIFF);
            place_word($urandom_range(0, len - 1), red_pkg::MARK_RIFX);
         end
         default: ;
      endcase
      // header last so that it takes precedence in the file
      case ($urandom_range(0, 9))
         0: place_word(0, red_pkg::MARK_RIFF);
         1: place_word(0, red_pkg::MARK_RIFX);
         default: ;
      endcase
   endtask

   // ------------------------------------------------------------------
   // stimulus
   // ------------------------------------------------------------------
   initial begin : stimulus
      probe_row_type probes [$];
      probe_row_type row;
      int          len, start_bytes;
      bit          first_file;
      logic [31:0] size_pick, count_word;

      // directed files; verdicts typed in where they are obvious
      // single zero byte straight after reset: short file, nothing known
      add_probe(1'b0, 32'd0, 3'd0, 32'd0, 1, 72'h00, 1'b1,
                red_pkg::ORDER_UNKNOWN, red_pkg::BY_VOTE, probes);
      // register extremes and an all-ones byte: still too short for anything
      add_probe(1'b1, 32'hffffffff, 3'd7, 32'hffffffff, 1, 72'hff, 1'b1,
                red_pkg::ORDER_UNKNOWN, red_pkg::BY_VOTE, probes);
      // header words
      add_probe(1'b1, 32'd4, 3'd0, 32'd0, 4, 72'(red_pkg::MARK_RIFF), 1'b1,
                red_pkg::ORDER_LITTLE, red_pkg::BY_HEADER, probes);
      add_probe(1'b0, 32'd4, 3'd0, 32'd0, 4, 72'(red_pkg::MARK_RIFX), 1'b1,
                red_pkg::ORDER_BIG, red_pkg::BY_HEADER, probes);
      // a single marker off the header position
      add_probe(1'b0, 32'd4, 3'd0, 32'd0, 5, 72'({8'h00, red_pkg::MARK_RIFF}), 1'b1,
                red_pkg::ORDER_LITTLE, red_pkg::BY_MARKER, probes);
      add_probe(1'b0, 32'd4, 3'd0, 32'd0, 5, 72'({8'hff, red_pkg::MARK_RIFX}), 1'b1,
                red_pkg::ORDER_BIG, red_pkg::BY_MARKER, probes);
      // both markers and no names in use: falls through to an empty vote
      add_probe(1'b0, 32'd4, 3'd0, 32'd0, 9,
                {8'h00, red_pkg::MARK_RIFF, red_pkg::MARK_RIFX}, 1'b1,
                red_pkg::ORDER_UNKNOWN, red_pkg::BY_VOTE, probes);
      // one name with a big-endian length equal to half the size
      add_probe(1'b1, 32'd16, 3'd1, 32'h64617461, 8, 72'({32'h64617461, 32'd8}), 1'b0,
                red_pkg::ORDER_UNKNOWN, red_pkg::BY_VOTE, probes);

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      for (int r = 0; r < probes.size(); r++) begin
         row = probes[r];
         if (row.set_regs) begin
            settle();
            write_reg(red_pkg::CSR_FILE_SIZE, row.size);
            write_reg(red_pkg::CSR_NAME_COUNT, 32'(row.count));
            write_reg(red_pkg::CSR_NAME_0, row.name);
            csr_write_en <= 1'b0;
         end
         if (row.typed) typed_verdicts.push_back(row.verdict);
         file_bytes = {};
         for (int i = 0; i < row.len; i++) file_bytes.push_back(row.bytes[8 * (row.len - 1 - i) +: 8]);
         send_file();
      end

      // random files; registers change between files only when the block is idle
      start_bytes = bytes_sent;
      first_file  = 1'b1;
      while (bytes_sent - start_bytes < RANDOM_BYTES) begin
         if (first_file || $urandom_range(0, 2) == 0) begin
            first_file = 1'b0;
            len = pick_length();
            case ($urandom_range(0, 9))
               0: size_pick = 32'd0;
               1: size_pick = 32'hffffffff;
               2: size_pick = $urandom;
               3: size_pick = 32'(len + $urandom_range(1, 8));  // size mismatch
               default: size_pick = 32'(len);
            endcase
            // upper bits of the count write are don't-care
            count_word = $urandom;
            count_word[2:0] = 3'($urandom_range(0, 7));
            settle();
            write_reg(red_pkg::CSR_FILE_SIZE, size_pick);
            write_reg(red_pkg::CSR_NAME_COUNT, count_word);
            for (int i = 0; i < red_pkg::NAME_SLOTS; i++) begin
               write_reg(red_pkg::CSR_NAME_0 + 3'(i), pick_name());
            end
            csr_write_en <= 1'b0;
         end else if (size_reg >= 32'd1 && size_reg <= 32'd80 && $urandom_range(0, 3) != 0) begin
            len = int'(size_reg);
         end else begin
            len = pick_length();
         end
         // some files run at full rate on one or both sides
         req_rush = ($urandom_range(0, 3) == 0);
         rsp_rush = ($urandom_range(0, 3) == 0);
         build_file(len);
         send_file();
      end

      // drain, then give the block its latency once more for stray verdicts
      settle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (pending_verdicts.size() != 0) begin
         $display("%0t ns: %0d verdicts never arrived, expected %h, actual none",
                  $time, pending_verdicts.size(), pending_verdicts[0]);
         failures++;
      end
      if (failures == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

FILE: files.f
rtl/red_pkg.sv
rtl/red_queue.sv
rtl/red_front.sv
rtl/red_back.sv
rtl/riff_endianness_detector.sv
tb/sv/tb_riff_endianness_detector.sv
